// ===== hdl/cal_pkg.sv =====
// Shared constants, command codes and cell control types for the cursor list.
package cal_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN         = 4'd0,
        CMD_END           = 4'd1,
        CMD_NEXT          = 4'd2,
        CMD_PRIOR         = 4'd3,
        CMD_INSERT_AFTER  = 4'd4,
        CMD_INSERT_BEFORE = 4'd5,
        CMD_REMOVE        = 4'd6,
        CMD_REPLACE       = 4'd7,
        CMD_READ          = 4'd8,
        CMD_CLEAR         = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      at;
        logic [DATA_W-1:0]     value;
    } cell_ctl_t;

endpackage

// ===== hdl/cal_cell.sv =====
// One list cell: holds a word, takes a neighbour's on a shift, or loads the given value.
module cal_cell (
    input  logic                          clk,
    input  cal_pkg::cell_ctl_t            ctl,
    input  logic [cal_pkg::IDX_W-1:0]     index,
    input  logic [cal_pkg::DATA_W-1:0]    left_data,
    input  logic [cal_pkg::DATA_W-1:0]    right_data,
    output logic [cal_pkg::DATA_W-1:0]    data
);
    import cal_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                // Cells beyond the insertion point move one place towards the end.
                if (index > ctl.at)
                begin
                    data_next = left_data;
                end
                else if (index == ctl.at)
                begin
                    data_next = ctl.value;
                end
            end
            CELL_REMOVE:
            begin
                if (index >= ctl.at)
                begin
                    data_next = right_data;
                end
            end
            CELL_WRITE:
            begin
                if (index == ctl.at)
                begin
                    data_next = ctl.value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hdl/cal_ctrl.sv =====
// Command decoder with count, cursor and capacity registers and the result register.
module cal_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cal_pkg::CMD_W-1:0]     command,
    input  logic [cal_pkg::DATA_W-1:0]    value,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          cfg_we,
    input  logic [cal_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic [cal_pkg::DATA_W-1:0]    cursor_data,
    output logic [cal_pkg::IDX_W-1:0]     cursor,
    output cal_pkg::cell_ctl_t            cell_ctl,
    output logic                          ok,
    output logic [cal_pkg::DATA_W-1:0]    read_value,
    output logic [cal_pkg::CNT_W-1:0]     entry_count,
    output logic [cal_pkg::IDX_W-1:0]     position,
    output logic                          is_empty,
    output logic                          is_full
);
    import cal_pkg::*;

    logic [CNT_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  cursor_reg;
    logic [IDX_W-1:0]  cursor_next;
    logic              out_valid_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;
    logic              is_empty_reg;
    logic              is_full_reg;

    logic              accept;
    logic [CNT_W-1:0]  eff_cap;
    logic              list_full;
    logic [CNT_W-1:0]  cursor_wide;
    cell_op_t          op_c;
    logic [IDX_W-1:0]  at_c;

    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign cursor_wide = {1'b0, cursor_reg};

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (capacity_reg > CNT_W'(MAX_ENTRIES))
        begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = capacity_reg;
        end
    end

    assign list_full = count_reg >= eff_cap;

    always_comb
    begin
        ok_next         = 1'b0;
        read_value_next = '0;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        op_c            = CELL_HOLD;
        at_c            = cursor_reg;
        case (cmd_t'(command))
            CMD_BEGIN:
            begin
                cursor_next = '0;
                ok_next     = 1'b1;
            end
            CMD_END:
            begin
                if (count_reg != '0)
                begin
                    cursor_next = IDX_W'(count_reg - CNT_W'(1));
                    ok_next     = 1'b1;
                end
            end
            CMD_NEXT:
            begin
                if (count_reg != '0 && (cursor_wide + CNT_W'(1)) < count_reg)
                begin
                    cursor_next = cursor_reg + IDX_W'(1);
                    ok_next     = 1'b1;
                end
            end
            CMD_PRIOR:
            begin
                if (count_reg != '0 && cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - IDX_W'(1);
                    ok_next     = 1'b1;
                end
            end
            CMD_INSERT_AFTER, CMD_INSERT_BEFORE:
            begin
                if (count_reg == '0)
                begin
                    op_c        = CELL_INSERT;
                    at_c        = '0;
                    cursor_next = '0;
                    count_next  = CNT_W'(1);
                    ok_next     = 1'b1;
                end
                else if (!list_full)
                begin
                    // The insertion point stays below the depth because the list is not full.
                    op_c        = CELL_INSERT;
                    at_c        = (cmd_t'(command) == CMD_INSERT_AFTER)
                                  ? cursor_reg + IDX_W'(1) : cursor_reg;
                    cursor_next = at_c;
                    count_next  = count_reg + CNT_W'(1);
                    ok_next     = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (count_reg != '0)
                begin
                    op_c            = CELL_REMOVE;
                    read_value_next = cursor_data;
                    count_next      = count_reg - CNT_W'(1);
                    // Removing the last entry sends the cursor back to the start.
                    if (cursor_wide >= count_next)
                    begin
                        cursor_next = '0;
                    end
                    ok_next = 1'b1;
                end
            end
            CMD_REPLACE:
            begin
                if (count_reg != '0)
                begin
                    op_c    = CELL_WRITE;
                    ok_next = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (count_reg != '0)
                begin
                    read_value_next = cursor_data;
                    ok_next         = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                if (count_reg != '0)
                begin
                    count_next  = '0;
                    cursor_next = '0;
                    ok_next     = 1'b1;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cell_ctl.op    = accept ? op_c : CELL_HOLD;
        cell_ctl.at    = at_c;
        cell_ctl.value = value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CNT_W'(MAX_ENTRIES);
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                cursor_reg    <= cursor_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg         <= ok_next;
            read_value_reg <= read_value_next;
            is_empty_reg   <= (count_next == '0);
            is_full_reg    <= (count_next >= eff_cap);
        end
    end

    assign cursor      = cursor_reg;
    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign read_value  = read_value_reg;
    assign entry_count = count_reg;
    assign position    = cursor_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;

endmodule

// ===== hdl/cursor_array_list_unit.sv =====
// Top level of the cursor list: control unit and the chain of storage cells.
// A result is registered and appears in the cycle after its command beat is accepted.
// One command per cycle unless the result side stalls; every cell shifts from its
// neighbour in parallel, so inserts and removes anywhere finish when accepted.
// Reset clears the count, the cursor and the output valid, and sets the capacity to 64;
// the stored words are not cleared and only words below the count are ever read.
module cursor_array_list_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cal_pkg::CMD_W-1:0]     command,
    input  logic signed [cal_pkg::DATA_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic signed [cal_pkg::DATA_W-1:0] read_value,
    output logic [cal_pkg::CNT_W-1:0]     entry_count,
    output logic [cal_pkg::IDX_W-1:0]     position,
    output logic                          is_empty,
    output logic                          is_full,
    input  logic                          cfg_we,
    input  logic [cal_pkg::CNT_W-1:0]     cfg_wdata
);
    import cal_pkg::*;

    cell_ctl_t         cell_ctl;
    logic [IDX_W-1:0]  cursor;
    logic [DATA_W-1:0] cell_data [MAX_ENTRIES];
    logic [DATA_W-1:0] cursor_data;
    logic [DATA_W-1:0] read_value_raw;

    cal_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cursor_data (cursor_data),
        .cursor      (cursor),
        .cell_ctl    (cell_ctl),
        .ok          (ok),
        .read_value  (read_value_raw),
        .entry_count (entry_count),
        .position    (position),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    assign read_value = read_value_raw;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        // The ends of the chain feed back their own word.
        assign left_d  = (g == 0) ? cell_data[g] : cell_data[(g == 0) ? 0 : g - 1];
        assign right_d = (g == MAX_ENTRIES - 1)
                         ? cell_data[g]
                         : cell_data[(g == MAX_ENTRIES - 1) ? g : g + 1];

        cal_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .index      (IDX_W'(g)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g])
        );
    end

    // AND-OR selection of the word under the cursor.
    always_comb
    begin
        cursor_data = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cursor == IDX_W'(i))
            begin
                cursor_data = cursor_data | cell_data[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted command produced no result");

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_empty) |-> ({1'b0, position} < entry_count))
        else $error("cursor points beyond the last entry");

    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (read_value == '0))
        else $error("refused command returned a word");

    a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (position == '0 && !is_full))
        else $error("empty list with cursor away from start or flagged full");
`endif

endmodule

// ===== tb/cursor_array_list_unit_tb.sv =====
// Self-checking testbench for the cursor list: directed and random commands against a tracker.
module cursor_array_list_unit_tb;
    import cal_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         entry_count;
        logic [IDX_W-1:0]         position;
        logic                     is_empty;
        logic                     is_full;
    } list_reply_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    // Mirrors the list contents, count and cursor, and queues the reply each command should give.
    class list_tracker;
        logic [DATA_W-1:0] words [MAX_ENTRIES];
        int                count;
        int                cursor;
        logic [CNT_W-1:0]  capacity;
        list_reply_t       replies [$];
        int                errors;
        int                checked;
        int                refused;
        int                peak;

        function new();
            count    = 0;
            cursor   = 0;
            capacity = CNT_W'(MAX_ENTRIES);
            errors   = 0;
            checked  = 0;
            refused  = 0;
            peak     = 0;
        endfunction

        function void set_capacity(logic [CNT_W-1:0] cap);
            capacity = cap;
        endfunction

        // A zero capacity behaves as one, and anything above the store depth as the depth.
        function int room();
            int lim;
            lim = (capacity == 0) ? 1 : int'(capacity);
            if (lim > MAX_ENTRIES)
                lim = MAX_ENTRIES;
            return lim;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        function void apply_command(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v);
            list_reply_t r;
            int          at;
            int          i;
            r = '0;
            case (c)
                CMD_BEGIN:
                begin
                    cursor = 0;
                    r.ok   = 1'b1;
                end
                CMD_END:
                    if (count != 0)
                    begin
                        cursor = count - 1;
                        r.ok   = 1'b1;
                    end
                CMD_NEXT:
                    if (count != 0 && cursor + 1 < count)
                    begin
                        cursor++;
                        r.ok = 1'b1;
                    end
                CMD_PRIOR:
                    if (count != 0 && cursor != 0)
                    begin
                        cursor--;
                        r.ok = 1'b1;
                    end
                CMD_INSERT_AFTER, CMD_INSERT_BEFORE:
                    if (count == 0)
                    begin
                        words[0] = v;
                        cursor   = 0;
                        count    = 1;
                        r.ok     = 1'b1;
                    end
                    else if (count < room())
                    begin
                        at = (c == CMD_INSERT_AFTER) ? cursor + 1 : cursor;
                        for (i = count; i > at; i--)
                            words[i] = words[i - 1];
                        words[at] = v;
                        cursor    = at;
                        count++;
                        r.ok = 1'b1;
                    end
                CMD_REMOVE:
                    if (count != 0)
                    begin
                        r.read_value = words[cursor];
                        for (i = cursor; i + 1 < count; i++)
                            words[i] = words[i + 1];
                        count--;
                        // Removing the last entry sends the cursor back to the front.
                        if (cursor >= count)
                            cursor = 0;
                        r.ok = 1'b1;
                    end
                CMD_REPLACE:
                    if (count != 0)
                    begin
                        words[cursor] = v;
                        r.ok          = 1'b1;
                    end
                CMD_READ:
                    if (count != 0)
                    begin
                        r.read_value = words[cursor];
                        r.ok         = 1'b1;
                    end
                CMD_CLEAR:
                    if (count != 0)
                    begin
                        count  = 0;
                        cursor = 0;
                        r.ok   = 1'b1;
                    end
                default:
                    ;
            endcase
            r.entry_count = CNT_W'(count);
            r.position    = IDX_W'(cursor);
            r.is_empty    = (count == 0);
            r.is_full     = (count >= room());
            if (!r.ok)
                refused++;
            if (count > peak)
                peak = count;
            replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_reply(list_reply_t got);
            list_reply_t want;
            if (replies.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing outstanding, actual %h", $time, got);
                return;
            end
            want = replies.pop_front();
            checked++;
            compare_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("entry_count", DATA_W'(want.entry_count), DATA_W'(got.entry_count));
            compare_field("position", DATA_W'(want.position), DATA_W'(got.position));
            compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
            compare_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         command = CMD_BEGIN;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         entry_count;
    logic [IDX_W-1:0]         position;
    logic                     is_empty;
    logic                     is_full;
    logic                     cfg_we = 1'b0;
    logic [CNT_W-1:0]         cfg_wdata = '0;

    list_tracker tracker;
    list_reply_t seen;
    bit          steady = 1'b0;
    int          cycles = 0;
    int          settings_used = 1;

    cursor_array_list_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .read_value  (read_value),
        .entry_count (entry_count),
        .position    (position),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, tracker.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 35);

    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            tracker.apply_command(command, value);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.ok          = ok;
            seen.read_value  = read_value;
            seen.entry_count = entry_count;
            seen.position    = position;
            seen.is_empty    = is_empty;
            seen.is_full     = is_full;
            tracker.check_reply(seen);
        end
    end

    // Valid is only lowered when a gap is taken, so a back-to-back beat never sees two updates.
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        tracker.set_capacity(cap);
        settings_used++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CMD_W-1:0] pick_command(mix_t mix);
        int roll;
        int ins;
        int rem;
        roll = $urandom_range(0, 99);
        ins  = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 15 : 35;
        rem  = (mix == MIX_FILL) ? 5 : (mix == MIX_DRAIN) ? 45 : 20;
        if (roll < ins)
            return roll[0] ? CMD_INSERT_AFTER : CMD_INSERT_BEFORE;
        if (roll < ins + rem)
            return CMD_REMOVE;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return CMD_W'($urandom_range(CMD_BEGIN, CMD_PRIOR));
        if (roll < 70)
            return CMD_READ;
        if (roll < 90)
            return CMD_REPLACE;
        if (roll < 94)
            return (mix == MIX_FILL) ? CMD_READ : CMD_CLEAR;
        return CMD_W'($urandom_range(CMD_CLEAR + 1, (1 << CMD_W) - 1));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return {1'b1, {(DATA_W - 1){1'b0}}};
            1:       return {1'b0, {(DATA_W - 1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input logic [CNT_W-1:0] cap, input mix_t mix, input int n,
                             input bit calm);
        write_capacity(cap);
        steady = calm;
        repeat (n)
            send_item(pick_command(mix), pick_value());
        steady = 1'b0;
    endtask

    initial
    begin
        int waited;
        tracker = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Every command on an empty list, then a short list walked end to end.
        send_item(CMD_READ, 32'h1111_1111);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_END, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_PRIOR, '0);
        send_item(CMD_REPLACE, 32'h2222_2222);
        send_item(CMD_CLEAR, '0);
        send_item(CMD_BEGIN, '0);
        send_item(CMD_INSERT_BEFORE, 32'h7FFF_FFFF);
        send_item(CMD_INSERT_AFTER, 32'h8000_0000);
        send_item(CMD_INSERT_BEFORE, '0);
        send_item(CMD_INSERT_AFTER, '1);
        send_item(CMD_END, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_PRIOR, '0);
        send_item(CMD_BEGIN, '0);
        send_item(CMD_PRIOR, '0);
        send_item(CMD_READ, '0);
        send_item(CMD_REPLACE, 32'h5A5A_A5A5);
        send_item(CMD_END, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_W'(CMD_CLEAR + 1), 32'h0BAD_F00D);
        send_item('1, '1);
        send_item(CMD_CLEAR, '0);

        // A list of two refuses a third word.
        write_capacity(CNT_W'(2));
        send_item(CMD_INSERT_AFTER, 32'h0000_0001);
        send_item(CMD_INSERT_AFTER, 32'h0000_0002);
        send_item(CMD_INSERT_BEFORE, 32'h0000_0003);
        send_item(CMD_REMOVE, '0);

        run_phase(CNT_W'(0), MIX_EVEN, 40, 1'b0);
        run_phase('1, MIX_FILL, 110, 1'b0);
        // Capacity may drop below the count here; the list then reads full until it drains below five.
        run_phase(CNT_W'(5), MIX_DRAIN, 50, 1'b0);
        run_phase(CNT_W'(MAX_ENTRIES), MIX_EVEN, 60, 1'b1);
        run_phase(CNT_W'(3), MIX_FILL, 40, 1'b0);
        run_phase(CNT_W'(100), MIX_FILL, 90, 1'b0);
        run_phase(CNT_W'(1), MIX_EVEN, 40, 1'b0);
        run_phase(CNT_W'(16), MIX_EVEN, 60, 1'b0);
        run_phase(CNT_W'($urandom_range(0, 127)), MIX_DRAIN, 50, 1'b0);
        run_phase(CNT_W'($urandom_range(0, 127)), MIX_EVEN, 50, 1'b0);

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (tracker.pending() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, tracker.pending());
            tracker.errors += tracker.pending();
        end

        $display("Checked %0d results over %0d capacity settings; %0d commands were refused.",
                 tracker.checked, settings_used, tracker.refused);
        $display("The list held at most %0d entries during the run.", tracker.peak);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
